### src/rv64dec_pkg.sv
// ----------------------------------------------------------------------------
// rv64dec_pkg
// Opcodes, mnemonic codes, operand forms and the decoded item type shared by
// the rv64i subset decoder.
// ----------------------------------------------------------------------------
package rv64dec_pkg;

  localparam int unsigned InstrW = 32;
  localparam int unsigned MnemW  = 6;
  localparam int unsigned RegW   = 5;

  localparam logic [6:0] OPC_OPIMM = 7'b0010011;
  localparam logic [6:0] OPC_LUI   = 7'b0110111;
  localparam logic [6:0] OPC_JAL   = 7'b1101111;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;
  localparam logic [6:0] OPC_OP    = 7'b0110011;

  localparam logic [31:0] LUI_MASK = 32'b11111111111111111111000000000000;

  localparam logic [5:0] F6_ZERO  = 6'b000000;
  localparam logic [5:0] F6_ARITH = 6'b010000;
  localparam logic [6:0] F7_ZERO  = 7'b0000000;
  localparam logic [6:0] F7_ALT   = 7'b0100000;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  typedef enum logic [MnemW-1:0] {
    MN_INV   = 6'd0,
    MN_ADDI  = 6'd1,
    MN_SLLI  = 6'd2,
    MN_SLTI  = 6'd3,
    MN_SLTIU = 6'd4,
    MN_XORI  = 6'd5,
    MN_SRLI  = 6'd6,
    MN_SRAI  = 6'd7,
    MN_ORI   = 6'd8,
    MN_ANDI  = 6'd9,
    MN_LUI   = 6'd10,
    MN_JAL   = 6'd11,
    MN_JALR  = 6'd12,
    MN_LB    = 6'd13,
    MN_LH    = 6'd14,
    MN_LW    = 6'd15,
    MN_LD    = 6'd16,
    MN_LBU   = 6'd17,
    MN_LHU   = 6'd18,
    MN_LWU   = 6'd19,
    MN_SB    = 6'd20,
    MN_SH    = 6'd21,
    MN_SW    = 6'd22,
    MN_SD    = 6'd23,
    MN_ADD   = 6'd24,
    MN_SUB   = 6'd25,
    MN_SLL   = 6'd26,
    MN_SLT   = 6'd27,
    MN_SLTU  = 6'd28,
    MN_XOR   = 6'd29,
    MN_SRL   = 6'd30,
    MN_SRA   = 6'd31,
    MN_OR    = 6'd32,
    MN_AND   = 6'd33
  } mnem_e;

  typedef enum logic [2:0] {
    FORM_INV   = 3'd0,
    FORM_RRI   = 3'd1,
    FORM_RI    = 3'd2,
    FORM_LOAD  = 3'd3,
    FORM_STORE = 3'd4,
    FORM_RRR   = 3'd5
  } form_e;

  typedef struct packed {
    mnem_e              mnemonic;
    form_e              form;
    logic [RegW-1:0]    rd;
    logic [RegW-1:0]    rs1;
    logic [RegW-1:0]    rs2;
    logic signed [31:0] imm;
  } dec_t;

endpackage

### src/rv64dec_decode.sv
// ----------------------------------------------------------------------------
// rv64dec_decode
// Combinational decode of one instruction word into mnemonic, form,
// register numbers and immediate (shift amounts zero-extended); unsupported words give zeros.
// ----------------------------------------------------------------------------
module rv64dec_decode (
  input  logic [rv64dec_pkg::InstrW-1:0] instr_i,
  output rv64dec_pkg::dec_t              dec_o
);
  import rv64dec_pkg::*;

  logic [6:0]        opc;
  logic [RegW-1:0]   rd;
  logic [2:0]        f3;
  logic [RegW-1:0]   r1;
  logic [RegW-1:0]   r2;
  logic [6:0]        f7;
  logic [5:0]        f6;
  logic [31:0]       i12;
  logic [31:0]       s12;
  logic [31:0]       j21;
  logic [31:0]       sh;
  dec_t              raw;

  assign opc = instr_i[6:0];
  assign rd  = instr_i[11:7];
  assign f3  = instr_i[14:12];
  assign r1  = instr_i[19:15];
  assign r2  = instr_i[24:20];
  assign f7  = instr_i[31:25];
  assign f6  = instr_i[31:26];
  assign i12 = {{20{instr_i[31]}}, instr_i[31:20]};
  assign s12 = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign j21 = {{12{instr_i[31]}}, instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
  assign sh  = {26'd0, instr_i[25:20]};

  always_comb begin
    raw          = '0;
    raw.mnemonic = MN_INV;
    raw.form     = FORM_INV;
    case (opc)
      OPC_OPIMM: begin
        raw.form = FORM_RRI;
        raw.rd   = rd;
        raw.rs1  = r1;
        raw.imm  = i12;
        case (f3)
          F3_ADD:  raw.mnemonic = MN_ADDI;
          F3_SLT:  raw.mnemonic = MN_SLTI;
          F3_SLTU: raw.mnemonic = MN_SLTIU;
          F3_XOR:  raw.mnemonic = MN_XORI;
          F3_OR:   raw.mnemonic = MN_ORI;
          F3_AND:  raw.mnemonic = MN_ANDI;
          F3_SLL: begin
            raw.imm = sh;
            if (f6 == F6_ZERO) raw.mnemonic = MN_SLLI;
          end
          F3_SR: begin
            raw.imm = sh;
            if (f6 == F6_ZERO) raw.mnemonic = MN_SRLI;
            else if (f6 == F6_ARITH) raw.mnemonic = MN_SRAI;
          end
          default: raw.mnemonic = MN_INV;
        endcase
      end
      OPC_LUI: begin
        raw.mnemonic = MN_LUI;
        raw.form     = FORM_RI;
        raw.rd       = rd;
        raw.imm      = instr_i & LUI_MASK;
      end
      OPC_JAL: begin
        raw.mnemonic = MN_JAL;
        raw.form     = FORM_RI;
        raw.rd       = rd;
        raw.imm      = j21;
      end
      OPC_JALR: begin
        raw.mnemonic = MN_JALR;
        raw.form     = FORM_RRI;
        raw.rd       = rd;
        raw.rs1      = r1;
        raw.imm      = i12;
      end
      OPC_LOAD: begin
        raw.form = FORM_LOAD;
        raw.rd   = rd;
        raw.rs1  = r1;
        raw.imm  = i12;
        case (f3)
          3'd0:    raw.mnemonic = MN_LB;
          3'd1:    raw.mnemonic = MN_LH;
          3'd2:    raw.mnemonic = MN_LW;
          3'd3:    raw.mnemonic = MN_LD;
          3'd4:    raw.mnemonic = MN_LBU;
          3'd5:    raw.mnemonic = MN_LHU;
          3'd6:    raw.mnemonic = MN_LWU;
          default: raw.mnemonic = MN_INV;
        endcase
      end
      OPC_STORE: begin
        raw.form = FORM_STORE;
        raw.rs1  = r1;
        raw.rs2  = r2;
        raw.imm  = s12;
        case (f3)
          3'd0:    raw.mnemonic = MN_SB;
          3'd1:    raw.mnemonic = MN_SH;
          3'd2:    raw.mnemonic = MN_SW;
          3'd3:    raw.mnemonic = MN_SD;
          default: raw.mnemonic = MN_INV;
        endcase
      end
      OPC_OP: begin
        raw.form = FORM_RRR;
        raw.rd   = rd;
        raw.rs1  = r1;
        raw.rs2  = r2;
        if (f7 == F7_ZERO) begin
          case (f3)
            F3_ADD:  raw.mnemonic = MN_ADD;
            F3_SLL:  raw.mnemonic = MN_SLL;
            F3_SLT:  raw.mnemonic = MN_SLT;
            F3_SLTU: raw.mnemonic = MN_SLTU;
            F3_XOR:  raw.mnemonic = MN_XOR;
            F3_SR:   raw.mnemonic = MN_SRL;
            F3_OR:   raw.mnemonic = MN_OR;
            F3_AND:  raw.mnemonic = MN_AND;
            default: raw.mnemonic = MN_INV;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          raw.mnemonic = MN_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          raw.mnemonic = MN_SRA;
        end
      end
      default: raw.mnemonic = MN_INV;
    endcase
  end

  // invalid words clear every field
  always_comb begin
    dec_o = raw;
    if (raw.mnemonic == MN_INV) begin
      dec_o          = '0;
      dec_o.mnemonic = MN_INV;
      dec_o.form     = FORM_INV;
    end
  end

endmodule

### src/rv64i_subset_instruction_decoder.sv
// ----------------------------------------------------------------------------
// rv64i_subset_instruction_decoder
// Order: start loads the word into instr_q and sets in_vld_q; in_vld_q loads
// the decoded item into dec_q and sets done_q, which drives done_o.
// Throughput: one item per cycle; busy is always low, the receiver cannot
// stall and the input and result registers form a two-stage pipeline.
// Reset clears the stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module rv64i_subset_instruction_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [rv64dec_pkg::InstrW-1:0]      instr_i,
  output logic                                done_o,
  output logic [rv64dec_pkg::MnemW-1:0]       mnemonic_o,
  output logic [2:0]                          form_o,
  output logic [rv64dec_pkg::RegW-1:0]        rd_o,
  output logic [rv64dec_pkg::RegW-1:0]        rs1_o,
  output logic [rv64dec_pkg::RegW-1:0]        rs2_o,
  output logic signed [31:0]                  imm_o
);
  import rv64dec_pkg::*;

  logic [InstrW-1:0] instr_q;
  logic              in_vld_q;
  dec_t              dec_d;
  dec_t              dec_q;
  logic              done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      instr_q <= instr_i;
    end
    if (in_vld_q) begin
      dec_q <= dec_d;
    end
  end

  rv64dec_decode u_decode (
    .instr_i (instr_q),
    .dec_o   (dec_d)
  );

  assign done_o     = done_q;
  assign mnemonic_o = dec_q.mnemonic;
  assign form_o     = dec_q.form;
  assign rd_o       = dec_q.rd;
  assign rs1_o      = dec_q.rs1;
  assign rs2_o      = dec_q.rs2;
  assign imm_o      = dec_q.imm;

endmodule

### sim/rv64i_subset_instruction_decoder_tb.sv
// ----------------------------------------------------------------------------
// rv64i_subset_instruction_decoder_tb
// Drives instruction words into the rv64i subset decoder and checks every
// decoded item against an in-bench decoder: field extremes, immediate layouts,
// malformed encodings, then a long random stream under several idle patterns.
// ----------------------------------------------------------------------------
module rv64i_subset_instruction_decoder_tb;
  import rv64dec_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 500;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [InstrW-1:0]       instr_i;
  logic                    done_o;
  logic [MnemW-1:0]        mnemonic_o;
  logic [2:0]              form_o;
  logic [RegW-1:0]         rd_o;
  logic [RegW-1:0]         rs1_o;
  logic [RegW-1:0]         rs2_o;
  logic signed [31:0]      imm_o;

  dec_t        decoded_q[$];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_invalid;
  int unsigned cycle_cnt;
  int unsigned idle_pct;
  bit          mnem_seen [0:63];

  rv64i_subset_instruction_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .instr_i    (instr_i),
    .done_o     (done_o),
    .mnemonic_o (mnemonic_o),
    .form_o     (form_o),
    .rd_o       (rd_o),
    .rs1_o      (rs1_o),
    .rs2_o      (rs2_o),
    .imm_o      (imm_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic dec_t decode_instr(input logic [31:0] w);
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [31:0] i12;
    dec_t        d;
    opc = w[6:0];
    f3  = w[14:12];
    f7  = w[31:25];
    f6  = w[31:26];
    i12 = {{20{w[31]}}, w[31:20]};
    d   = '0;
    case (opc)
      OPC_OPIMM: begin
        d.form = FORM_RRI;
        d.rd   = w[11:7];
        d.rs1  = w[19:15];
        d.imm  = i12;
        case (f3)
          F3_ADD:  d.mnemonic = MN_ADDI;
          F3_SLT:  d.mnemonic = MN_SLTI;
          F3_SLTU: d.mnemonic = MN_SLTIU;
          F3_XOR:  d.mnemonic = MN_XORI;
          F3_OR:   d.mnemonic = MN_ORI;
          F3_AND:  d.mnemonic = MN_ANDI;
          F3_SLL: begin
            d.imm = {26'd0, w[25:20]};
            if (f6 == F6_ZERO) d.mnemonic = MN_SLLI;
          end
          default: begin
            d.imm = {26'd0, w[25:20]};
            if (f6 == F6_ZERO) d.mnemonic = MN_SRLI;
            else if (f6 == F6_ARITH) d.mnemonic = MN_SRAI;
          end
        endcase
      end
      OPC_LUI: begin
        d.mnemonic = MN_LUI;
        d.form     = FORM_RI;
        d.rd       = w[11:7];
        d.imm      = w & LUI_MASK;
      end
      OPC_JAL: begin
        d.mnemonic = MN_JAL;
        d.form     = FORM_RI;
        d.rd       = w[11:7];
        d.imm      = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR: begin
        d.mnemonic = MN_JALR;
        d.form     = FORM_RRI;
        d.rd       = w[11:7];
        d.rs1      = w[19:15];
        d.imm      = i12;
      end
      OPC_LOAD: begin
        if (f3 != 3'd7) d.mnemonic = mnem_e'(MN_LB + f3);
        d.form = FORM_LOAD;
        d.rd   = w[11:7];
        d.rs1  = w[19:15];
        d.imm  = i12;
      end
      OPC_STORE: begin
        if (f3 < 3'd4) d.mnemonic = mnem_e'(MN_SB + f3);
        d.form = FORM_STORE;
        d.rs1  = w[19:15];
        d.rs2  = w[24:20];
        d.imm  = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_OP: begin
        d.form = FORM_RRR;
        d.rd   = w[11:7];
        d.rs1  = w[19:15];
        d.rs2  = w[24:20];
        if (f7 == F7_ZERO) begin
          case (f3)
            F3_ADD:  d.mnemonic = MN_ADD;
            F3_SLL:  d.mnemonic = MN_SLL;
            F3_SLT:  d.mnemonic = MN_SLT;
            F3_SLTU: d.mnemonic = MN_SLTU;
            F3_XOR:  d.mnemonic = MN_XOR;
            F3_SR:   d.mnemonic = MN_SRL;
            F3_OR:   d.mnemonic = MN_OR;
            default: d.mnemonic = MN_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          d.mnemonic = MN_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          d.mnemonic = MN_SRA;
        end
      end
      default: d = '0;
    endcase
    if (d.mnemonic == MN_INV) d = '0;
    return d;
  endfunction

  // mostly well-formed words with random fields, the rest raw noise
  function automatic logic [31:0] rand_instr();
    logic [6:0]  opcs [7] = '{OPC_OPIMM, OPC_LUI, OPC_JAL, OPC_JALR,
                              OPC_LOAD, OPC_STORE, OPC_OP};
    logic [31:0] w;
    int unsigned sel;
    w   = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 12) return w;
    w[6:0] = opcs[$urandom_range(0, 6)];
    if (w[6:0] == OPC_OPIMM && (w[14:12] == F3_SLL || w[14:12] == F3_SR) &&
        $urandom_range(0, 3) != 0) begin
      w[31:26] = (w[14:12] == F3_SR && $urandom_range(0, 1)) ? F6_ARITH : F6_ZERO;
    end
    if (w[6:0] == OPC_OP && $urandom_range(0, 3) != 0) begin
      w[31:25] = ((w[14:12] == F3_ADD || w[14:12] == F3_SR) && $urandom_range(0, 1))
                 ? F7_ALT : F7_ZERO;
    end
    return w;
  endfunction

  task automatic send_instr(input logic [31:0] w);
    while ($urandom_range(0, 99) < idle_pct) begin
      start   = 1'b0;
      instr_i = $urandom;
      @(negedge clk_i);
    end
    start   = 1'b1;
    instr_i = w;
    do @(posedge clk_i); while (busy);
    decoded_q.push_back(decode_instr(w));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    dec_t want;
    if (rst_ni && done_o) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got mnemonic %0d",
                 $time, mnemonic_o);
        n_errors++;
      end else begin
        want = decoded_q.pop_front();
        check_field("mnemonic", 32'(want.mnemonic), 32'(mnemonic_o));
        check_field("form", 32'(want.form), 32'(form_o));
        check_field("rd", 32'(want.rd), 32'(rd_o));
        check_field("rs1", 32'(want.rs1), 32'(rs1_o));
        check_field("rs2", 32'(want.rs2), 32'(rs2_o));
        check_field("imm", want.imm, imm_o);
        n_checked++;
        mnem_seen[mnemonic_o] = 1'b1;
        if (want.mnemonic == MN_INV) n_invalid++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d items outstanding", $time, decoded_q.size());
      $display("[rv64i_subset_instruction_decoder] ERROR");
      $finish;
    end
  end

  task automatic test_field_extremes();
    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    send_instr({12'hFFF, 5'd31, F3_ADD, 5'd31, OPC_OPIMM});
    send_instr({12'h7FF, 5'd0, F3_ADD, 5'd0, OPC_OPIMM});
    send_instr({12'h800, 5'd31, F3_AND, 5'd0, OPC_OPIMM});
    send_instr({20'hFFFFF, 5'd31, OPC_LUI});
    send_instr({20'h00000, 5'd0, OPC_LUI});
  endtask

  task automatic test_immediate_forms();
    send_instr({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd1, OPC_JAL});
    send_instr({1'b1, 10'h000, 1'b0, 8'h00, 5'd31, OPC_JAL});
    send_instr({1'b1, 10'h155, 1'b0, 8'hA5, 5'd17, OPC_JAL});
    send_instr({7'h7F, 5'd31, 5'd31, 3'd3, 5'h1F, OPC_STORE});
    send_instr({7'h40, 5'd0, 5'd1, 3'd0, 5'h00, OPC_STORE});
    send_instr({F6_ZERO, 6'd63, 5'd7, F3_SLL, 5'd9, OPC_OPIMM});
    send_instr({F6_ARITH, 6'd63, 5'd31, F3_SR, 5'd31, OPC_OPIMM});
    send_instr({F6_ZERO, 6'd0, 5'd3, F3_SR, 5'd4, OPC_OPIMM});
    send_instr({12'hFFF, 5'd12, 3'd7, 5'd13, OPC_JALR});
  endtask

  task automatic test_invalid_encodings();
    send_instr({25'h1AB_CDEF, 7'h7F});
    send_instr({6'b000001, 6'd5, 5'd2, F3_SLL, 5'd3, OPC_OPIMM});
    send_instr({6'b010001, 6'd5, 5'd2, F3_SR, 5'd3, OPC_OPIMM});
    send_instr({6'b110000, 6'd5, 5'd2, F3_SR, 5'd3, OPC_OPIMM});
    send_instr({12'h123, 5'd4, 3'd7, 5'd5, OPC_LOAD});
    send_instr({7'h12, 5'd6, 5'd7, 3'd4, 5'd8, OPC_STORE});
    send_instr({7'h12, 5'd6, 5'd7, 3'd7, 5'd8, OPC_STORE});
    send_instr({7'b0000001, 5'd9, 5'd10, F3_ADD, 5'd11, OPC_OP});
    send_instr({F7_ALT, 5'd9, 5'd10, F3_SLL, 5'd11, OPC_OP});
    send_instr({F7_ALT, 5'd31, 5'd30, F3_ADD, 5'd29, OPC_OP});
    send_instr({F7_ALT, 5'd1, 5'd2, F3_SR, 5'd3, OPC_OP});
  endtask

  task automatic test_random_stream(input int unsigned gap_pct);
    idle_pct = gap_pct;
    repeat (PhaseItems) send_instr(rand_instr());
    idle_pct = 0;
  endtask

  initial begin
    int unsigned n_kinds;
    start     = 1'b0;
    instr_i   = '0;
    rst_ni    = 1'b0;
    idle_pct  = 0;
    n_errors  = 0;
    n_sent    = 0;
    n_checked = 0;
    n_invalid = 0;
    cycle_cnt = 0;
    n_kinds   = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_field_extremes();
    test_immediate_forms();
    test_invalid_encodings();
    test_random_stream(0);
    test_random_stream(49);
    // result side cannot stall, so this phase runs back to back again
    test_random_stream(0);
    test_random_stream(38);

    start = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    for (int i = 0; i < 64; i++) if (mnem_seen[i]) n_kinds++;
    $display("decoded %0d of %0d words, %0d of them invalid encodings",
             n_checked, n_sent, n_invalid);
    $display("%0d distinct mnemonic codes observed, %0d mismatches", n_kinds, n_errors);
    if (n_errors == 0) begin
      $display("[rv64i_subset_instruction_decoder] OK");
    end else begin
      $display("[rv64i_subset_instruction_decoder] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/rv64dec_pkg.sv
src/rv64dec_decode.sv
src/rv64i_subset_instruction_decoder.sv
sim/rv64i_subset_instruction_decoder_tb.sv
